[hdl/fprc_pkg.sv]
// ----------------------------------------------------------------------------
// fprc_pkg
// Types, codes and the CRC-16/XMODEM byte update for the framed packet
// receiver.
// ----------------------------------------------------------------------------
package fprc_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int STORE_AW    = 9;

    localparam logic [7:0] START_SHORT = 8'd2;
    localparam logic [7:0] START_LONG  = 8'd3;
    localparam logic [7:0] END_BYTE    = 8'd3;

    localparam logic       CMD_FEED = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [8:0] read_index;
    } in_t;

    typedef struct packed {
        logic       frame_ok;
        logic [9:0] frame_length;
        logic [7:0] read_data;
    } out_t;

    typedef enum logic [7:0] {
        PH_WAIT     = 8'b0000_0001,
        PH_LEN8     = 8'b0000_0010,
        PH_LEN16_HI = 8'b0000_0100,
        PH_LEN16_LO = 8'b0000_1000,
        PH_DATA     = 8'b0001_0000,
        PH_CRC_HI   = 8'b0010_0000,
        PH_CRC_LO   = 8'b0100_0000,
        PH_STOP     = 8'b1000_0000
    } phase_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/framed_packet_receiver_crc16_core.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_core
// Parses a byte stream into length-prefixed frames, stores the payload in a
// 512 x 8 memory, checks CRC-16/XMODEM and serves reads of stored bytes.
// ----------------------------------------------------------------------------
// Pipeline: request accept, then the memory read stage, then the output
//   register drives result valid.
// Throughput: one request per cycle unless m_ready holds the output; at most
//   one CRC byte update and one memory access per request.
// Reset: synchronous on aresetn low; clears parser state and the pipeline.
//   Payload memory is not cleared.
module framed_packet_receiver_crc16_core #(
    parameter int MAX_PAYLOAD = 512
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fprc_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output fprc_pkg::out_t  m_data
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    fprc_pkg::phase_t   phase_reg, phase_next;
    logic [LEN_W-1:0]   exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [7:0]         len_hi_reg, len_hi_next;
    logic [15:0]        rx_crc_reg, rx_crc_next;
    logic [15:0]        run_crc_reg, run_crc_next;

    logic [7:0]         store [fprc_pkg::STORE_DEPTH];
    logic [7:0]         rdata_reg;

    logic               p1_valid_reg;
    logic               p1_cmd_reg;
    logic               p1_ok_reg;
    logic [9:0]         p1_len_reg;

    logic               out_valid_reg;
    fprc_pkg::out_t     out_data_reg;

    logic               accept;
    logic               feed;
    logic               out_load;
    logic               p1_move;
    logic               ok_now;
    logic [15:0]        len_cand;
    logic [15:0]        pos_wide;
    logic               store_we;
    logic [LEN_W-1:0]   pos_inc;

    assign out_load = !out_valid_reg || m_ready;
    assign p1_move  = p1_valid_reg && out_load;
    assign s_ready  = !p1_valid_reg || out_load;
    assign accept   = s_valid && s_ready;
    assign feed     = accept && (s_data.command == fprc_pkg::CMD_FEED);
    assign pos_wide = 16'(pos_reg);
    assign pos_inc  = pos_reg + LEN_W'(1);
    assign store_we = feed && (phase_reg == fprc_pkg::PH_DATA)
                      && (pos_wide < 16'(fprc_pkg::STORE_DEPTH));

    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        pos_next     = pos_reg;
        len_hi_next  = len_hi_reg;
        rx_crc_next  = rx_crc_reg;
        run_crc_next = run_crc_reg;
        ok_now       = 1'b0;
        len_cand     = (phase_reg == fprc_pkg::PH_LEN8) ? {8'h00, s_data.rx_byte}
                                                        : {len_hi_reg, s_data.rx_byte};
        if (feed) begin
            unique case (phase_reg)
                fprc_pkg::PH_WAIT: begin
                    if (s_data.rx_byte == fprc_pkg::START_SHORT) begin
                        phase_next = fprc_pkg::PH_LEN8;
                    end else if (s_data.rx_byte == fprc_pkg::START_LONG) begin
                        phase_next = fprc_pkg::PH_LEN16_HI;
                    end
                end
                fprc_pkg::PH_LEN16_HI: begin
                    len_hi_next = s_data.rx_byte;
                    phase_next  = fprc_pkg::PH_LEN16_LO;
                end
                fprc_pkg::PH_LEN8, fprc_pkg::PH_LEN16_LO: begin
                    if (len_cand == 16'd0 || 17'(len_cand) > 17'(MAX_PAYLOAD)) begin
                        phase_next   = fprc_pkg::PH_WAIT;
                        exp_len_next = '0;
                        pos_next     = '0;
                        rx_crc_next  = '0;
                        run_crc_next = '0;
                    end else begin
                        exp_len_next = LEN_W'(len_cand);
                        pos_next     = '0;
                        run_crc_next = '0;
                        phase_next   = fprc_pkg::PH_DATA;
                    end
                end
                fprc_pkg::PH_DATA: begin
                    run_crc_next = fprc_pkg::crc_update(run_crc_reg, s_data.rx_byte);
                    pos_next     = pos_inc;
                    if (pos_inc >= exp_len_reg) begin
                        phase_next = fprc_pkg::PH_CRC_HI;
                    end
                end
                fprc_pkg::PH_CRC_HI: begin
                    rx_crc_next = {s_data.rx_byte, 8'h00};
                    phase_next  = fprc_pkg::PH_CRC_LO;
                end
                fprc_pkg::PH_CRC_LO: begin
                    rx_crc_next = {rx_crc_reg[15:8], s_data.rx_byte};
                    phase_next  = fprc_pkg::PH_STOP;
                end
                fprc_pkg::PH_STOP: begin
                    ok_now       = (s_data.rx_byte == fprc_pkg::END_BYTE)
                                   && (rx_crc_reg == run_crc_reg);
                    exp_len_next = '0;
                    pos_next     = '0;
                    rx_crc_next  = '0;
                    run_crc_next = '0;
                    phase_next   = (s_data.rx_byte == fprc_pkg::START_SHORT)
                                   ? fprc_pkg::PH_LEN8 : fprc_pkg::PH_WAIT;
                end
                default: begin
                    phase_next = fprc_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= fprc_pkg::PH_WAIT;
            exp_len_reg <= '0;
            pos_reg     <= '0;
            len_hi_reg  <= '0;
            rx_crc_reg  <= '0;
            run_crc_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            pos_reg     <= pos_next;
            len_hi_reg  <= len_hi_next;
            rx_crc_reg  <= rx_crc_next;
            run_crc_reg <= run_crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store[pos_wide[fprc_pkg::STORE_AW-1:0]] <= s_data.rx_byte;
        end
        if (accept && s_data.command == fprc_pkg::CMD_READ) begin
            rdata_reg <= store[s_data.read_index];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_cmd_reg <= s_data.command;
            p1_ok_reg  <= ok_now;
            p1_len_reg <= ok_now ? 10'(exp_len_reg) : 10'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            out_data_reg.frame_ok     <= p1_ok_reg;
            out_data_reg.frame_length <= p1_len_reg;
            out_data_reg.read_data    <= (p1_cmd_reg == fprc_pkg::CMD_READ) ? rdata_reg : 8'h00;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_ok |-> m_data.read_data == 8'h00)
        else $error("frame_ok with nonzero read_data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("request accepted while pipeline is full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !p1_cmd_reg && !p1_ok_reg |-> p1_len_reg == 10'd0)
        else $error("frame_length set without frame_ok");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !p1_valid_reg && phase_reg == fprc_pkg::PH_WAIT)
        else $error("pipeline or parser not cleared by reset");

endmodule
